[rtl/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes for the periodic timer table: operation codes,
// result kinds, stream layout widths and the slot memory entry.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // operation selector carried on s_tuser
    localparam logic [1:0] FUNC_PASS   = 2'd0;
    localparam logic [1:0] FUNC_CREATE = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    // result kind carried on m_tuser
    localparam logic [1:0] KIND_FIRE = 2'd0;
    localparam logic [1:0] KIND_PASS = 2'd1;
    localparam logic [1:0] KIND_OP   = 2'd2;

    localparam int TIME_W = 32;
    localparam int SLOT_W = 4;
    localparam int REP_W  = 16;

    localparam logic [TIME_W-1:0] NO_TIMER_DELAY = '1;
    localparam logic [TIME_W-1:0] DISABLED_DELAY = TIME_W'(1);

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic                    callback;
        logic [TIME_W-1:0]       period;
        logic [TIME_W-1:0]       last_run;
        logic signed [REP_W-1:0] rep_cnt;
    } slot_entry_t;

endpackage

[rtl/periodic_timer_table.sv]
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of software-style timer slots with repeat counts, scanned by a
// handler pass that reports expiries and the least remaining time.
// ----------------------------------------------------------------------------
// A create, a delete, an unused operation code or a handler pass while
// handling is disabled goes through the op state, which loads its single
// result into the result register; the next item can be taken after that.
// An enabled handler pass starts the read of slot 0 on the input transfer,
// then handles one slot per cycle through the single read port of the slot
// memory and one shared expiry/remaining-time unit, pausing while a fire
// waits for the result register, then reports the least delay from the done
// state. Any result that finds the result register still occupied waits on
// m_tready. The block takes no new item until the last result of the current
// one is in the result register.
module periodic_timer_table #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // handling_enable
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] now, [35:32] slot, [67:36] period, [83:68] reps_left,
    // [84] autorun, [85] has_callback, [87:86] zero
    input  logic [ptt_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] func
    input  logic [1:0]                         s_tuser,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [3:0] fired_slot, [35:4] next_delay, [39:36] zero
    output logic [ptt_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // [1:0] kind
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_OP   = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // control
    logic [1:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] run_reg, run_next;
    logic                 enable_reg;
    logic                 rem_ok_reg, rem_ok_next;
    logic                 m_valid_reg, m_valid_next;

    // payload
    logic [ptt_pkg::TIME_W-1:0] best_reg, best_next;
    logic [ptt_pkg::TIME_W-1:0] rem_reg, rem_next;
    logic [1:0]                 func_reg;
    logic [ptt_pkg::TIME_W-1:0] now_reg;
    logic [ptt_pkg::SLOT_W-1:0] slot_reg;
    logic [ptt_pkg::TIME_W-1:0] period_reg;
    logic [ptt_pkg::REP_W-1:0]  rep_reg;
    logic                       autorun_reg;
    logic                       cb_reg;
    logic [1:0]                 m_kind_reg;
    logic [ptt_pkg::SLOT_W-1:0] m_slot_reg;
    logic [ptt_pkg::TIME_W-1:0] m_delay_reg;
    logic                       m_last_reg;

    // slot memory
    ptt_pkg::slot_entry_t slot_mem [NUM_SLOTS];
    ptt_pkg::slot_entry_t rd_q;
    ptt_pkg::slot_entry_t wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    // shared evaluation unit
    logic [ptt_pkg::TIME_W-1:0] elapsed;
    logic [ptt_pkg::TIME_W:0]   diff;
    logic                       expired;
    logic                       act;
    logic                       fire_go;
    logic signed [ptt_pkg::REP_W-1:0] new_rep;
    logic                       emit_fire;
    logic                       freed;
    logic                       stall;
    logic [ptt_pkg::TIME_W-1:0] rem_after;
    logic [ptt_pkg::TIME_W-1:0] final_best;

    logic                       in_xfer;
    logic                       out_free;
    logic                       slot_in_range;
    logic                       out_load;
    logic [1:0]                 out_kind;
    logic [ptt_pkg::SLOT_W-1:0] out_slot;
    logic [ptt_pkg::TIME_W-1:0] out_delay;
    logic                       out_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid & s_tready;
    assign out_free  = ~m_valid_reg | m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'b0, m_delay_reg, m_slot_reg};

    assign slot_in_range = (32'(slot_reg) < NUM_SLOTS);

    // expiry test and remaining time share one subtract: borrow or zero
    // means the period has been reached
    assign elapsed   = now_reg - rd_q.last_run;
    assign diff      = {1'b0, rd_q.period} - {1'b0, elapsed};
    assign expired   = diff[ptt_pkg::TIME_W] | (diff[ptt_pkg::TIME_W-1:0] == '0);
    assign act       = valid_reg[idx_reg] & run_reg[idx_reg];
    assign fire_go   = act & expired;
    assign new_rep   = (fire_go && rd_q.rep_cnt > 0) ? rd_q.rep_cnt - 16'sd1 : rd_q.rep_cnt;
    assign emit_fire = fire_go & rd_q.callback & (rd_q.rep_cnt != '0);
    assign freed     = act & (new_rep == '0);
    assign stall     = emit_fire & ~out_free;
    // a restamped slot has its whole period left
    assign rem_after = fire_go ? rd_q.period
                     : (expired ? '0 : diff[ptt_pkg::TIME_W-1:0]);

    assign final_best = (rem_ok_reg && rem_reg < best_reg) ? rem_reg : best_reg;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        run_next    = run_reg;
        rem_next    = rem_reg;
        rem_ok_next = rem_ok_reg;
        best_next   = final_best;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_q;
        out_load    = 1'b0;
        out_kind    = ptt_pkg::KIND_OP;
        out_slot    = slot_reg;
        out_delay   = '0;
        out_last    = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == ptt_pkg::FUNC_PASS && enable_reg) begin
                        state_next  = ST_SCAN;
                        idx_next    = '0;
                        rd_en       = 1'b1;
                        rd_addr     = '0;
                        best_next   = ptt_pkg::NO_TIMER_DELAY;
                        rem_ok_next = 1'b0;
                    end else begin
                        state_next = ST_OP;
                    end
                end
            end
            ST_OP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    wr_addr    = IDX_W'(slot_reg);
                    wr_data    = '{callback: cb_reg, period: period_reg,
                                   last_run: now_reg, rep_cnt: rep_reg};
                    if (func_reg == ptt_pkg::FUNC_PASS) begin
                        // pass while handling is disabled
                        out_kind  = ptt_pkg::KIND_PASS;
                        out_slot  = '0;
                        out_delay = ptt_pkg::DISABLED_DELAY;
                    end else if (slot_in_range) begin
                        if (func_reg == ptt_pkg::FUNC_CREATE) begin
                            wr_en                        = 1'b1;
                            valid_next[IDX_W'(slot_reg)] = 1'b1;
                            run_next[IDX_W'(slot_reg)]   = autorun_reg;
                        end else if (func_reg == ptt_pkg::FUNC_DELETE) begin
                            valid_next[IDX_W'(slot_reg)] = 1'b0;
                            run_next[IDX_W'(slot_reg)]   = 1'b0;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    wr_en            = fire_go;
                    wr_data.last_run = now_reg;
                    wr_data.rep_cnt  = new_rep;
                    if (freed) begin
                        valid_next[idx_reg] = 1'b0;
                        run_next[idx_reg]   = 1'b0;
                    end
                    rem_next    = rem_after;
                    rem_ok_next = valid_reg[idx_reg] & ~freed;
                    out_load    = emit_fire;
                    out_kind    = ptt_pkg::KIND_FIRE;
                    out_slot    = ptt_pkg::SLOT_W'(idx_reg);
                    out_last    = 1'b0;
                    if (idx_reg == IDX_W'(NUM_SLOTS - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = ptt_pkg::KIND_PASS;
                    out_slot   = '0;
                    out_delay  = final_best;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            valid_reg   <= '0;
            run_reg     <= '0;
            enable_reg  <= 1'b0;
            rem_ok_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
            run_reg     <= run_next;
            rem_ok_reg  <= rem_ok_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
        rem_reg  <= rem_next;
        if (in_xfer) begin
            func_reg    <= s_tuser;
            now_reg     <= s_tdata[31:0];
            slot_reg    <= s_tdata[35:32];
            period_reg  <= s_tdata[67:36];
            rep_reg     <= s_tdata[83:68];
            autorun_reg <= s_tdata[84];
            cb_reg      <= s_tdata[85];
        end
        if (out_load) begin
            m_kind_reg  <= out_kind;
            m_slot_reg  <= out_slot;
            m_delay_reg <= out_delay;
            m_last_reg  <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q <= slot_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // a slot can only run while it is allocated
    assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg & ~valid_reg) == '0)
        else $error("running flag set on a free slot");

    // fires never close an item, every other result does
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser != ptt_pkg::KIND_FIRE)))
        else $error("tlast does not match result kind");

    // the sequencer is busy in the cycle after it takes an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while previous item still in work");

    // no result is produced while the block is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !m_valid_reg) |=> !m_valid_reg)
        else $error("result appeared without an item in work");
`endif

endmodule
